[sv/srs_pkg.sv]
package srs_pkg;

    // Record indices, generator state and counts all share one word width
    localparam int unsigned DATA_W = 32;
    localparam int unsigned SIZE_W = 7;
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned MAX_SLOTS = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_SIZE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEED        = 1'd1;

    localparam logic [DATA_W-1:0] ZERO_SEED_MAP = 32'h9E37_79B9;
    localparam logic [DATA_W-1:0] COUNT_MAX     = 32'hFFFF_FFFF;

    function automatic logic [DATA_W-1:0] xorshift32(input logic [DATA_W-1:0] s);
        logic [DATA_W-1:0] x;
        x = s;
        x = x ^ (x << 13);
        x = x ^ (x >> 17);
        x = x ^ (x << 5);
        return x;
    endfunction

    function automatic logic [DATA_W-1:0] map_seed(input logic [DATA_W-1:0] s);
        return (s == '0) ? ZERO_SEED_MAP : s;
    endfunction

endpackage

[sv/srs_ram.sv]
module srs_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 64,
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[sv/srs_div.sv]
module srs_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [srs_pkg::DATA_W-1:0]  dividend,
    input  logic [srs_pkg::DATA_W-1:0]  divisor,
    output logic                        done,
    output logic [srs_pkg::DATA_W-1:0]  remainder
);

    localparam int unsigned W  = srs_pkg::DATA_W;
    localparam int unsigned CW = $clog2(W);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [W-1:0]  dvd_reg, dsr_reg, rem_reg;
    logic [W:0]    trial;
    logic [W:0]    rem_next;

    // Restoring remainder: shift in one dividend bit, subtract if it fits
    assign trial    = {rem_reg, dvd_reg[W-1]};
    assign rem_next = (trial >= {1'b0, dsr_reg}) ? (trial - {1'b0, dsr_reg}) : trial;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dsr_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[W-2:0], 1'b0};
            rem_reg <= rem_next[W-1:0];
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

[sv/seeded_reservoir_sampler.sv]
// Channel   Direction  Handshake            Payload
// ------    ---------  -------------------  ------------------------------------------
// in        sink       in_valid/in_ready    last_record
// out       source     out_valid/out_ready  slot_record_index, keep_all, records_seen,
//                                           count_overflow, last_of_run
// cfg       sink       cfg_we (no wait)     cfg_index, cfg_wdata
//
// Free-slot, saturated and keep-everything records are taken directly; a record past
// the reservoir takes a draw (generator step, the serial remainder unit, check),
// repeated on a rejected draw. A final record then picks its run, and emits each slot
// by a RAM read and an output load, or a keep-all by a single output load.
// Reset is asynchronous, active low, and leaves the slot contents as they were.
// Output stalls hold only emission; input is taken while the last result waits.
module seeded_reservoir_sampler #(
    parameter int unsigned MAX_SLOTS = srs_pkg::MAX_SLOTS
) (
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            last_record,

    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [srs_pkg::DATA_W-1:0]      slot_record_index,
    output logic                            keep_all,
    output logic [srs_pkg::DATA_W-1:0]      records_seen,
    output logic                            count_overflow,
    output logic                            last_of_run,

    input  logic                            cfg_we,
    input  logic [srs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [srs_pkg::DATA_W-1:0]      cfg_wdata
);

    localparam int unsigned W  = srs_pkg::DATA_W;
    localparam int unsigned SW = srs_pkg::SIZE_W;
    localparam int unsigned AW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam logic [SW-1:0] MAX_N = SW'(MAX_SLOTS);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DRAW,
        S_DIV,
        S_CHECK,
        S_EMIT,
        S_EMIT_ONE,
        S_EMIT_RD,
        S_EMIT_LOAD
    } state_t;

    state_t         state_reg;
    logic [SW-1:0]  sample_size_reg;
    logic [W-1:0]   seed_reg;
    logic [W-1:0]   rng_reg;
    logic [W-1:0]   count_reg;
    logic           ovf_reg;
    logic           last_reg;
    logic [W-1:0]   rand_reg;
    logic [SW-1:0]  k_reg;

    logic           out_valid_reg;
    logic [W-1:0]   slot_idx_reg;
    logic           keep_all_reg;
    logic [W-1:0]   seen_reg;
    logic           ovf_out_reg;
    logic           last_run_reg;

    logic [SW-1:0]  n_eff;
    logic           accept;
    logic           out_free;
    logic           out_load;
    logic [W-1:0]   rng_step;
    logic [W-1:0]   bound;
    logic           div_done;
    logic [W-1:0]   div_rem;
    logic [W:0]     next_mult;
    logic           reject;
    logic           j_in_res;
    logic           i_in_res;
    logic           copy_case;

    logic           ram_we;
    logic [AW-1:0]  ram_waddr;
    logic           ram_re;
    logic [W-1:0]   ram_rdata;

    // Clamp the sample size to the reservoir depth
    assign n_eff    = (sample_size_reg > MAX_N) ? MAX_N : sample_size_reg;
    assign accept   = in_valid && (state_reg == S_IDLE);
    assign in_ready = (state_reg == S_IDLE);
    assign out_free = !out_valid_reg || out_ready;
    assign out_load = ((state_reg == S_EMIT_ONE) || (state_reg == S_EMIT_LOAD)) && out_free;
    assign rng_step = srs_pkg::xorshift32(rng_reg);
    assign bound    = count_reg + 1'b1;

    // A draw is rejected when it lies in the last block of
    // multiples of the bound: the next multiple past it no longer fits 32 bits
    assign next_mult = {1'b0, rand_reg - div_rem} + {1'b0, bound};
    assign reject    = next_mult[W];
    assign j_in_res  = (div_rem < W'(n_eff));
    assign i_in_res  = (count_reg < W'(n_eff));
    assign copy_case = (n_eff == '0) || (count_reg <= W'(n_eff));

    // Fill slot i while the reservoir is not full, replace slot j after a draw
    assign ram_we    = (accept && (count_reg != srs_pkg::COUNT_MAX) && i_in_res)
                    || ((state_reg == S_CHECK) && !reject && j_in_res);
    assign ram_waddr = (state_reg == S_CHECK) ? div_rem[AW-1:0] : count_reg[AW-1:0];
    assign ram_re    = (state_reg == S_EMIT_RD);

    srs_ram #(
        .WIDTH (W),
        .DEPTH (MAX_SLOTS)
    ) u_slots (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (count_reg),
        .re    (ram_re),
        .raddr (k_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    srs_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (state_reg == S_DRAW),
        .dividend  (rng_step),
        .divisor   (bound),
        .done      (div_done),
        .remainder (div_rem)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            sample_size_reg <= '0;
            seed_reg        <= '0;
            rng_reg         <= srs_pkg::ZERO_SEED_MAP;
            count_reg       <= '0;
            ovf_reg         <= 1'b0;
            last_reg        <= 1'b0;
            k_reg           <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            // Drop the result once the sink takes it, unless the next one loads
            if (out_valid_reg && out_ready && !out_load)
            begin
                out_valid_reg <= 1'b0;
            end

            // Write registers only while idle (unchecked); seed reloads the generator
            if (cfg_we)
            begin
                unique case (cfg_index)
                    srs_pkg::CFG_SAMPLE_SIZE: sample_size_reg <= cfg_wdata[SW-1:0];
                    srs_pkg::CFG_SEED:
                    begin
                        seed_reg <= cfg_wdata;
                        rng_reg  <= srs_pkg::map_seed(cfg_wdata);
                    end
                    default: ;
                endcase
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        last_reg <= last_record;
                        if (count_reg == srs_pkg::COUNT_MAX)
                        begin
                            // Saturated: flag it, sample nothing
                            ovf_reg   <= 1'b1;
                            state_reg <= last_record ? S_EMIT : S_IDLE;
                        end
                        else if (i_in_res || (n_eff == '0))
                        begin
                            count_reg <= bound;
                            state_reg <= last_record ? S_EMIT : S_IDLE;
                        end
                        else
                        begin
                            state_reg <= S_DRAW;
                        end
                    end
                end
                S_DRAW:
                begin
                    // Advance the generator and hand the draw to the divider
                    rng_reg   <= rng_step;
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        state_reg <= S_CHECK;
                    end
                end
                S_CHECK:
                begin
                    if (reject)
                    begin
                        state_reg <= S_DRAW;
                    end
                    else
                    begin
                        count_reg <= bound;
                        state_reg <= last_reg ? S_EMIT : S_IDLE;
                    end
                end
                S_EMIT:
                begin
                    k_reg     <= '0;
                    state_reg <= copy_case ? S_EMIT_ONE : S_EMIT_RD;
                end
                S_EMIT_ONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        count_reg     <= '0;
                        ovf_reg       <= 1'b0;
                        rng_reg       <= srs_pkg::map_seed(seed_reg);
                        state_reg     <= S_IDLE;
                    end
                end
                S_EMIT_RD:
                begin
                    state_reg <= S_EMIT_LOAD;
                end
                S_EMIT_LOAD:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        if (k_reg + 1'b1 == n_eff)
                        begin
                            // Run complete: clear the stream and reseed
                            count_reg <= '0;
                            ovf_reg   <= 1'b0;
                            rng_reg   <= srs_pkg::map_seed(seed_reg);
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            k_reg     <= k_reg + 1'b1;
                            state_reg <= S_EMIT_RD;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // Payload registers: hold the draw and the result being offered
    always_ff @(posedge clk)
    begin
        if (state_reg == S_DRAW)
        begin
            rand_reg <= rng_step;
        end
        if ((state_reg == S_EMIT_ONE) && out_free)
        begin
            slot_idx_reg <= '0;
            keep_all_reg <= 1'b1;
            seen_reg     <= count_reg;
            ovf_out_reg  <= ovf_reg;
            last_run_reg <= 1'b1;
        end
        else if ((state_reg == S_EMIT_LOAD) && out_free)
        begin
            slot_idx_reg <= ram_rdata;
            keep_all_reg <= 1'b0;
            seen_reg     <= count_reg;
            ovf_out_reg  <= ovf_reg;
            last_run_reg <= (k_reg + 1'b1 == n_eff);
        end
    end

    assign out_valid         = out_valid_reg;
    assign slot_record_index = slot_idx_reg;
    assign keep_all          = keep_all_reg;
    assign records_seen      = seen_reg;
    assign count_overflow    = ovf_out_reg;
    assign last_of_run       = last_run_reg;

endmodule
